// ===== rtl/wait_for_graph_cycle_check_defines.svh =====
// Assertion macros shared by the wait-for graph cycle check RTL.
`ifndef WAIT_FOR_GRAPH_CYCLE_CHECK_DEFINES_SVH
`define WAIT_FOR_GRAPH_CYCLE_CHECK_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WFGCC_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wait-for graph check: same-cycle property failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WFGCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wait-for graph check: next-cycle property failed");

`endif

// ===== rtl/wfgcc_pkg.sv =====
// Package with the field widths, item kind codes and default sizes of the cycle check.
package wfgcc_pkg;

  // Fixed widths of the word fields.
  localparam int KIND_W       = 2;
  localparam int PROC_FIELD_W = 4;
  localparam int RES_FIELD_W  = 4;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SET_WAIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_OWNER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 2'd2;

  // Default table sizes.
  localparam int DEF_NUM_PROCS = 16;
  localparam int DEF_NUM_RES   = 16;

  typedef logic [PROC_FIELD_W-1:0] proc_field_t;
  typedef logic [RES_FIELD_W-1:0]  res_field_t;

endpackage

// ===== rtl/wait_for_graph_cycle_check.sv =====
// Wait-for graph deadlock checker: process and resource tables with a chain-walking sequencer.
//
// Usage. Input words arrive on item_valid / item_stall with fields kind, process_index,
// resource_index and entry_valid. A word is taken on a rising edge with item_valid high and
// item_stall low. Kind "set wait" writes one process entry, kind "set owner" writes one
// resource entry; neither produces a result. Kind "query" walks the wait chain from the
// named process and returns one word on result_valid / result_stall carrying deadlocked.
// Any other kind is dropped.
// Walk. A query holds item_stall high while it walks, so no new word is taken until its
// result has gone to the output register. Each hop of the chain is one registered read of
// the process table followed by one of the resource table, and the visited marks bound
// the walk to NUM_PROCS hops.
// Reset. rst (synchronous, active high) clears all wait and owner flags, so every process
// starts without an outgoing edge; no clearing pass is needed. The output register is
// emptied.
// Stalls. A result waits in the output register while result_stall is high; writes are
// still taken meanwhile, and a following query finishes its walk and then holds until
// the register frees up.
`include "wait_for_graph_cycle_check_defines.svh"

module wait_for_graph_cycle_check
  import wfgcc_pkg::*;
#(
  parameter int NUM_PROCS = DEF_NUM_PROCS,
  parameter int NUM_RES   = DEF_NUM_RES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [KIND_W-1:0]       kind,
  input  logic [PROC_FIELD_W-1:0] process_index,
  input  logic [RES_FIELD_W-1:0]  resource_index,
  input  logic                    entry_valid,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic                    deadlocked
);

  localparam int PIDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int RIDX_W = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_RES = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DONE   = 3'd3;

  logic [2:0] state, state_next;
  logic       verdict, verdict_next;
  logic [NUM_PROCS-1:0] visited, visited_next;

  // Table storage. The flags reset; the index memories are only read behind a set flag.
  logic [NUM_PROCS-1:0] wait_flag;
  logic [NUM_RES-1:0]   owner_flag;
  res_field_t           awaited_mem [NUM_PROCS];
  proc_field_t          owner_mem   [NUM_RES];

  // Registered read data.
  logic        wflag_rd;
  logic        oflag_rd;
  res_field_t  res_rd;
  proc_field_t own_rd;

  logic [PIDX_W-1:0] proc_raddr;
  logic [RIDX_W-1:0] res_raddr;
  logic [PIDX_W-1:0] own_idx;

  logic item_accept;
  logic wr_proc, wr_res;
  logic p_in_range, wr_res_in_range, rd_res_in_range, own_in_range;
  logic slot_free;

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;

  assign p_in_range      = 32'(process_index) < NUM_PROCS;
  assign wr_res_in_range = 32'(resource_index) < NUM_RES;
  assign rd_res_in_range = 32'(res_rd) < NUM_RES;
  assign own_in_range    = 32'(own_rd) < NUM_PROCS;

  assign wr_proc = item_accept && (kind == KIND_SET_WAIT) && p_in_range;
  assign wr_res  = item_accept && (kind == KIND_SET_OWNER) && wr_res_in_range;

  assign own_idx   = PIDX_W'(own_rd);
  assign res_raddr = RIDX_W'(res_rd);
  assign slot_free = !result_valid || !result_stall;

  // One hop of the walk is RD_RES (check the waiter, read the owner) followed by
  // CHECK (check the owner, test the visited marks, read the next process).
  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    visited_next = visited;
    proc_raddr   = PIDX_W'(process_index);
    unique case (state)
      S_IDLE: begin
        if (item_accept && (kind == KIND_QUERY)) begin
          if (p_in_range) begin
            visited_next = '0;
            visited_next[PIDX_W'(process_index)] = 1'b1;
            state_next = S_RD_RES;
          end else begin
            verdict_next = 1'b0;
            state_next   = S_DONE;
          end
        end
      end
      S_RD_RES: begin
        if (!wflag_rd || !rd_res_in_range) begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        proc_raddr = own_idx;
        if (!oflag_rd || !own_in_range) begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end else if (visited[own_idx]) begin
          verdict_next = 1'b1;
          state_next   = S_DONE;
        end else begin
          visited_next[own_idx] = 1'b1;
          state_next = S_RD_RES;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      visited      <= '0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      visited <= visited_next;
      if (state == S_DONE && slot_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    verdict <= verdict_next;
    if (state == S_DONE && slot_free) begin
      deadlocked <= verdict;
    end
  end

  // Flags reset at once and are read through registers alongside the memories.
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_flag  <= '0;
      owner_flag <= '0;
    end else begin
      if (wr_proc) begin
        wait_flag[PIDX_W'(process_index)] <= entry_valid;
      end
      if (wr_res) begin
        owner_flag[RIDX_W'(resource_index)] <= entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    wflag_rd <= wait_flag[proc_raddr];
    oflag_rd <= owner_flag[res_raddr];
  end

  // Process table: awaited resource per process.
  always_ff @(posedge clk) begin
    if (wr_proc) begin
      awaited_mem[PIDX_W'(process_index)] <= resource_index;
    end
    res_rd <= awaited_mem[proc_raddr];
  end

  // Resource table: owning process per resource.
  always_ff @(posedge clk) begin
    if (wr_res) begin
      owner_mem[RIDX_W'(resource_index)] <= process_index;
    end
    own_rd <= owner_mem[res_raddr];
  end

  // A fresh result only ever comes out of the finishing state.
  `WFGCC_ASSERT_NOW(a_result_from_done, clk, rst, $rose(result_valid), $past(state) == S_DONE)
  // An in-range query starts its walk in the next cycle.
  `WFGCC_ASSERT_NEXT(a_query_starts_walk, clk, rst,
    item_accept && (kind == KIND_QUERY) && p_in_range, state == S_RD_RES)
  // While walking, at least the start process is marked.
  `WFGCC_ASSERT_NOW(a_walk_has_marks, clk, rst,
    (state == S_RD_RES) || (state == S_CHECK), visited != '0)
  // A hop that marks a new process grows the mark set by exactly one.
  `WFGCC_ASSERT_NEXT(a_one_mark_per_hop, clk, rst,
    (state == S_CHECK) && (state_next == S_RD_RES),
    $countones(visited) == $countones($past(visited)) + 1)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the wait-for graph deadlock checker.
`timescale 1ns / 100ps

module tb_top;
  import wfgcc_pkg::*;

  localparam int PROCS     = DEF_NUM_PROCS;
  localparam int RESOURCES = DEF_NUM_RES;
  // The fourth kind code is not used by the block; words carrying it are dropped.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // Bound on the longest query walk, taken from the number of processes.
  localparam int WALK_CYCLES = 2 * PROCS + 2;

  logic                    clk;
  logic                    rst;
  logic                    item_valid;
  logic                    item_stall;
  logic [KIND_W-1:0]       kind;
  logic [PROC_FIELD_W-1:0] process_index;
  logic [RES_FIELD_W-1:0]  resource_index;
  logic                    entry_valid;
  logic                    result_valid;
  logic                    result_stall;
  logic                    deadlocked;

  // Shadow copy of the block's tables, updated whenever a word is accepted.
  logic        proc_blocked [PROCS];
  proc_field_t proc_awaits  [PROCS];
  logic        res_held     [RESOURCES];
  proc_field_t res_holder   [RESOURCES];

  // Verdicts of accepted queries whose result word has not come back yet.
  logic verdicts_pending[$];

  int error_count = 0;
  int words_sent  = 0;
  // Percent chances, per cycle, that the sender idles and that the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  wait_for_graph_cycle_check u_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .kind           (kind),
    .process_index  (process_index),
    .resource_index (resource_index),
    .entry_valid    (entry_valid),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .deadlocked     (deadlocked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a correct run finishes well inside this window, so reaching it
  // means the block hung or stopped handing back results.
  initial begin
    #8_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Follows the single-successor wait chain from the start process. A process
  // has an outgoing edge only when it is blocked and its awaited resource has
  // an owner. Landing on an already visited process means a cycle, even when
  // the start process is not part of it.
  function automatic logic walk_finds_cycle(proc_field_t start);
    logic [PROCS-1:0] seen;
    proc_field_t      node;
    res_field_t       res;
    logic             found;
    seen  = '0;
    node  = start;
    found = 1'b0;
    seen[node] = 1'b1;
    for (int hop = 0; hop <= PROCS; hop++) begin
      if (!proc_blocked[node]) break;
      res = proc_awaits[node];
      if (!res_held[res]) break;
      node = res_holder[res];
      if (seen[node]) begin
        found = 1'b1;
        break;
      end
      seen[node] = 1'b1;
    end
    return found;
  endfunction

  // Applies one accepted word to the shadow tables, or queues the verdict for
  // a query. The unused kind changes nothing.
  function automatic void absorb_word(logic [KIND_W-1:0] k, proc_field_t p, res_field_t r,
                                      logic v);
    case (k)
      KIND_SET_WAIT: begin
        if (int'(p) < PROCS) begin
          proc_blocked[p] = v;
          proc_awaits[p]  = r;
        end
      end
      KIND_SET_OWNER: begin
        if (int'(r) < RESOURCES) begin
          res_held[r]   = v;
          res_holder[r] = p;
        end
      end
      KIND_QUERY: verdicts_pending.push_back(walk_finds_cycle(p));
      default: ;
    endcase
  endfunction

  // Drives one word at the falling edge and holds it until the block takes it.
  // Afterwards the sender may go quiet for a random number of cycles.
  task automatic send_word(logic [KIND_W-1:0] k, proc_field_t p, res_field_t r, logic v);
    @(negedge clk);
    item_valid     = 1'b1;
    kind           = k;
    process_index  = p;
    resource_index = r;
    entry_valid    = v;
    do @(posedge clk); while (item_stall);
    absorb_word(k, p, r, v);
    if (k != KIND_UNUSED) words_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      item_valid = 1'b0;
    end
  endtask

  task automatic send_query(proc_field_t p);
    // The resource and flag fields mean nothing to a query, so they carry noise.
    send_word(KIND_QUERY, p, res_field_t'($urandom_range(15)), logic'($urandom_range(1)));
  endtask

  // Lowers valid and waits until every queued verdict has been checked.
  task automatic drain_results();
    @(negedge clk);
    item_valid = 1'b0;
    while (verdicts_pending.size() != 0) @(posedge clk);
  endtask

  // Receiver: decides at every falling edge whether to hold off the next result.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      result_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: every result word taken is matched against the oldest verdict.
  always @(posedge clk) begin
    logic want;
    if (!rst && result_valid && !result_stall) begin
      if (verdicts_pending.size() == 0) begin
        $error("deadlocked: unexpected result word, actual %0b", deadlocked);
        error_count++;
      end else begin
        want = verdicts_pending.pop_front();
        if (deadlocked !== want) begin
          $error("deadlocked: expected %0b, actual %0b", want, deadlocked);
          error_count++;
        end
      end
    end
  end

  // After reset nobody waits and nobody owns anything, so no query can find a cycle.
  task automatic test_reset_state();
    send_query('0);
    send_query('1);
  endtask

  // Hand-built graphs covering the corner cases of the walk.
  task automatic test_special_cases();
    // A process that waits on a resource it owns itself is a cycle of one.
    send_word(KIND_SET_OWNER, 4'd3, 4'd5, 1'b1);
    send_word(KIND_SET_WAIT, 4'd3, 4'd5, 1'b1);
    send_query(4'd3);
    // The unused kind must leave the tables alone, even with fields that would clear them.
    send_word(KIND_UNUSED, 4'd3, 4'd5, 1'b0);
    send_query(4'd3);
    // Process 7 leads into the self-loop of process 3, a cycle not through the start.
    send_word(KIND_SET_WAIT, 4'd7, 4'd9, 1'b1);
    send_word(KIND_SET_OWNER, 4'd3, 4'd9, 1'b1);
    send_query(4'd7);
    // A chain that stops at a resource without owner, before and after an owner
    // write that has the valid flag low.
    send_word(KIND_SET_WAIT, 4'd15, 4'd0, 1'b1);
    send_query(4'd15);
    send_word(KIND_SET_OWNER, 4'd15, 4'd0, 1'b0);
    send_query(4'd15);
    // Withdrawing the wait of process 3 breaks both chains above.
    send_word(KIND_SET_WAIT, 4'd3, 4'd5, 1'b0);
    send_query(4'd3);
    send_query(4'd7);
    // A two-process cycle between the extreme indices.
    send_word(KIND_SET_WAIT, 4'd0, 4'd15, 1'b1);
    send_word(KIND_SET_OWNER, 4'd15, 4'd15, 1'b1);
    send_word(KIND_SET_OWNER, 4'd0, 4'd0, 1'b1);
    send_query(4'd0);
    send_query(4'd15);
  endtask

  // Builds a wait chain over distinct processes and resources, closed into a
  // cycle or left open at the end, then queries it. Sometimes one link is cut
  // before the queries so that broken chains are seen as well.
  task automatic build_and_query_chain(int len, logic close_loop);
    int procs_order[PROCS];
    int res_order[RESOURCES];
    int pick;
    int tmp;
    for (int i = 0; i < PROCS; i++) procs_order[i] = i;
    for (int i = 0; i < RESOURCES; i++) res_order[i] = i;
    for (int i = PROCS - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      tmp = procs_order[i]; procs_order[i] = procs_order[pick]; procs_order[pick] = tmp;
    end
    for (int i = RESOURCES - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      tmp = res_order[i]; res_order[i] = res_order[pick]; res_order[pick] = tmp;
    end
    for (int i = 0; i < len; i++) begin
      send_word(KIND_SET_WAIT, proc_field_t'(procs_order[i]), res_field_t'(res_order[i]),
                1'b1);
      if (i < len - 1 || close_loop)
        send_word(KIND_SET_OWNER, proc_field_t'(procs_order[(i + 1) % len]),
                  res_field_t'(res_order[i]), 1'b1);
    end
    if ($urandom_range(3) == 0) begin
      pick = $urandom_range(len - 1);
      if ($urandom_range(1))
        send_word(KIND_SET_WAIT, proc_field_t'(procs_order[pick]),
                  res_field_t'(res_order[pick]), 1'b0);
      else
        send_word(KIND_SET_OWNER, proc_field_t'(procs_order[(pick + 1) % len]),
                  res_field_t'(res_order[pick]), 1'b0);
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(3) != 0)
        send_query(proc_field_t'(procs_order[$urandom_range(len - 1)]));
      else
        send_query(proc_field_t'($urandom_range(15)));
    end
  endtask

  // Mostly well-formed chains with random shape and membership, with random
  // words mixed in. Most chains are short; now and then one spans every process.
  // Some stretches run with no idling on either side.
  task automatic test_random_chains(int word_budget, int idle_pct, int stall_pct);
    int stop_at;
    int len;
    stop_at = words_sent + word_budget;
    while (words_sent < stop_at) begin
      if ($urandom_range(7) == 0) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
      end
      if ($urandom_range(99) < 65) begin
        len = ($urandom_range(9) == 0) ? PROCS : $urandom_range(1, 6);
        build_and_query_chain(len, logic'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(KIND_W'($urandom_range(3)), proc_field_t'($urandom_range(15)),
                    res_field_t'($urandom_range(15)), logic'($urandom_range(1)));
      end
    end
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // The sender stops until every outstanding result has come back, then resumes;
  // the block has to pick up cleanly from a fully empty pipeline.
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 40;
    build_and_query_chain(PROCS, 1'b1);
    drain_results();
    build_and_query_chain(PROCS, 1'b0);
    send_query(proc_field_t'($urandom_range(15)));
    drain_results();
  endtask

  initial begin
    rst            = 1'b1;
    item_valid     = 1'b0;
    kind           = KIND_SET_WAIT;
    process_index  = '0;
    resource_index = '0;
    entry_valid    = 1'b0;
    for (int i = 0; i < PROCS; i++) begin
      proc_blocked[i] = 1'b0;
      proc_awaits[i]  = '0;
    end
    for (int i = 0; i < RESOURCES; i++) begin
      res_held[i]   = 1'b0;
      res_holder[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_special_cases();
    test_random_chains(450, 0, 0);
    test_random_chains(450, 59, 0);
    test_drain_pause();
    test_random_chains(450, 0, 59);
    test_random_chains(450, 24, 24);

    // Let the last walks finish, then give the block time to show any stray result.
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (WALK_CYCLES + 8) @(posedge clk);
    if (verdicts_pending.size() != 0) begin
      $error("deadlocked: %0d expected result words never arrived", verdicts_pending.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
